>>> design/sbeq_pkg.sv
// Shared types and constants for the stereo biquad equalizer.
package sbeq_pkg;

    localparam int BANDS_DEF          = 8;
    localparam int SAMPLE_BITS        = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;
    localparam int COEF_BITS          = 32;
    localparam int STATE_BITS         = 48;
    localparam int NCOEF              = 5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic [2:0] SEL_B0 = 3'd0;
    localparam logic [2:0] SEL_B1 = 3'd1;
    localparam logic [2:0] SEL_B2 = 3'd2;
    localparam logic [2:0] SEL_A1 = 3'd3;
    localparam logic [2:0] SEL_A2 = 3'd4;

endpackage

>>> design/sbeq_if.sv
// Valid/ready channel interfaces for the equalizer.
interface sbeq_in_if import sbeq_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        opcode;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic [2:0]  band_index;
    logic [2:0]  coef_select;
    logic signed [COEF_BITS-1:0] coef_value;
    modport source (output valid, opcode, left_in, right_in, band_index, coef_select,
                    coef_value, input ready);
    modport sink   (input valid, opcode, left_in, right_in, band_index, coef_select,
                    coef_value, output ready);
endinterface

interface sbeq_out_if import sbeq_pkg::*; ();
    logic        valid;
    logic        ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

>>> design/stereo_biquad_cascade_eq_unit.sv
// Top level: sequencer, coefficient and state memories, one shared multiplier.
// Coefficient write: taken while idle, ready stays high; no result word.
// Sample pair: each band filters the left then the right channel; in_ch.ready
// stays low until the result word is registered in S_OUT, and the next word is
// taken back in S_IDLE. A stalled result holds the next finished pair.
// Reset: a sweep sets each band to pass-through (b0 = 1.0, others 0) and clears state.
module stereo_biquad_cascade_eq_unit import sbeq_pkg::*; #(
    parameter int BANDS          = BANDS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbeq_in_if.sink    in_ch,
    sbeq_out_if.source out_ch
);
    localparam int SF_RAW     = STATE_BITS - SAMPLE_BITS - 4;
    localparam int STATE_FRAC = (SF_RAW < COEF_FRAC_BITS) ? SF_RAW : COEF_FRAC_BITS;
    localparam int NC    = BANDS * NCOEF;
    localparam int CAW   = $clog2(NC);
    localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int SD    = 1 << (BW + 2);
    localparam int CLR_N = (NC > SD) ? NC : SD;
    localparam int AW    = STATE_BITS + 4;
    localparam logic signed [STATE_BITS:0] RND_Y = (STATE_BITS+1)'(1) <<< (STATE_FRAC - 1);

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_RUN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // memories
    logic signed [COEF_BITS-1:0]  coef_mem [NC];
    logic signed [STATE_BITS-1:0] st_mem   [SD];
    logic signed [COEF_BITS-1:0]  r_coef_q;
    logic signed [STATE_BITS-1:0] r_st_q;

    t_state r_state, n_state;
    logic [CAW:0]   r_clr;
    logic [2:0]     r_clr_sel;
    logic [BW-1:0]  r_band;
    logic           r_ch;
    logic [2:0]     r_step;
    logic signed [SAMPLE_BITS-1:0] r_y, r_l, r_r, r_lo, r_ro;
    logic signed [AW-1:0]          r_acc;
    logic signed [AW-1:0]          r_s2;
    logic r_ovalid;

    logic signed [SAMPLE_BITS-1:0] w_mx;
    logic signed [STATE_BITS:0]    w_term;
    logic signed [AW-1:0]          w_t;
    logic                          w_in_acc;
    logic                          w_last;

    logic [2:0]     w_csel;
    logic [CAW+3:0] w_cidx;
    logic [CAW-1:0] w_caddr;
    logic [BW+1:0]  w_saddr;
    logic           w_swe;
    logic signed [STATE_BITS-1:0] w_swd;
    logic           w_cwe;
    logic [CAW-1:0] w_cwa;
    logic signed [COEF_BITS-1:0] w_cwd;

    sbeq_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
        .i_clk  (i_clk),
        .i_coef (r_coef_q),
        .i_x    (w_mx),
        .o_term (w_term)
    );

    function automatic logic signed [STATE_BITS-1:0] sat48(
        input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        begin
            hi = AW'({1'b0, {(STATE_BITS-1){1'b1}}});
            lo = -hi - AW'(1);
            if (v > hi) sat48 = hi[STATE_BITS-1:0];
            else if (v < lo) sat48 = lo[STATE_BITS-1:0];
            else sat48 = v[STATE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] ysat(
        input logic signed [STATE_BITS-1:0] a);
        logic signed [STATE_BITS:0] t;
        logic signed [STATE_BITS:0] hi, lo;
        begin
            t  = (STATE_BITS+1)'(a);
            t  = (t + RND_Y) >>> STATE_FRAC;
            hi = (STATE_BITS+1)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
            lo = -hi - (STATE_BITS+1)'(1);
            if (t > hi) ysat = hi[SAMPLE_BITS-1:0];
            else if (t < lo) ysat = lo[SAMPLE_BITS-1:0];
            else ysat = t[SAMPLE_BITS-1:0];
        end
    endfunction

    // Band step schedule (one channel); a read passes r_coef_q and r_prod before its product is used:
    // 0: read b0, s1   1: mul b0*x, read b1, s1   2: mul b1*x, read b2, s2; acc
    // 3: mul b2*x, read a1; y, s1 = b1x + s2      4: mul a1*y, read a2; s2 = b2x
    // 5: mul a2*y; s1 -= a1y   6: s2 -= a2y; write s1   7: write s2, advance
    always_comb begin
        case (r_step)
            3'd0:    w_csel = SEL_B0;
            3'd1:    w_csel = SEL_B1;
            3'd2:    w_csel = SEL_B2;
            3'd3:    w_csel = SEL_A1;
            3'd4:    w_csel = SEL_A2;
            default: w_csel = SEL_B0;
        endcase
    end

    always_comb begin
        w_cidx  = (CAW+4)'(r_band) * (CAW+4)'(NCOEF) + (CAW+4)'(w_csel);
        w_caddr = w_cidx[CAW-1:0];
        if (r_state == S_CLR) begin
            w_saddr = r_clr[BW+1:0];
        end else begin
            w_saddr = {r_ch, r_band, (r_step == 3'd2 || r_step == 3'd7)};
        end
        // operand x for b-terms, y for a-terms
        w_mx = (r_step == 3'd4 || r_step == 3'd5) ? r_y : (r_ch ? r_r : r_l);
    end

    assign w_in_acc = in_ch.valid && in_ch.ready;
    assign w_last   = (r_step == 3'd7) && r_ch && (r_band == BW'(BANDS-1));

    // coefficient memory write port
    always_comb begin
        w_cwe = 1'b0;
        w_cwa = r_clr[CAW-1:0];
        w_cwd = '0;
        if (r_state == S_CLR) begin
            w_cwe = r_clr < (CAW+1)'(NC);
            w_cwd = (r_clr_sel == SEL_B0) ? (COEF_BITS'(1) <<< COEF_FRAC_BITS) : '0;
        end else if (w_in_acc && in_ch.opcode == OP_COEF) begin
            w_cwe = (32'(in_ch.band_index) < 32'(BANDS)) &&
                    (in_ch.coef_select inside {SEL_B0, SEL_B1, SEL_B2, SEL_A1, SEL_A2});
            w_cwa = CAW'((CAW+4)'(in_ch.band_index) * (CAW+4)'(NCOEF) +
                         (CAW+4)'(in_ch.coef_select));
            w_cwd = in_ch.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) coef_mem[w_cwa] <= w_cwd;
        r_coef_q <= coef_mem[w_caddr];
        if (w_swe) st_mem[w_saddr] <= w_swd;
        r_st_q <= st_mem[w_saddr];
    end

    // state write: zeros during the reset sweep, s1 at step 6, s2 at step 7
    always_comb begin
        w_swe = 1'b0;
        w_swd = '0;
        if (r_state == S_CLR) begin
            w_swe = r_clr < (CAW+1)'(SD);
        end else if (r_state == S_RUN && r_step == 3'd6) begin
            w_swe = 1'b1;
            w_swd = sat48(r_acc);
        end else if (r_state == S_RUN && r_step == 3'd7) begin
            w_swe = 1'b1;
            w_swd = sat48(r_s2);
        end
    end

    assign w_t = AW'(w_term);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr == (CAW+1)'(CLR_N-1)) n_state = S_IDLE;
            S_IDLE: if (w_in_acc && in_ch.opcode == OP_SAMPLE) n_state = S_RUN;
            S_RUN:  if (w_last) n_state = S_OUT;
            S_OUT:  if (!r_ovalid || out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign in_ch.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_sel <= SEL_B0;
            r_ovalid  <= 1'b0;
            r_step    <= '0;
            r_band    <= '0;
            r_ch      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr     <= r_clr + 1'b1;
                r_clr_sel <= (r_clr_sel == SEL_A2) ? SEL_B0 : r_clr_sel + 3'd1;
            end
            if (r_state == S_OUT && (!r_ovalid || out_ch.ready)) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_band <= '0;
                    r_ch   <= 1'b0;
                    r_l    <= in_ch.left_in;
                    r_r    <= in_ch.right_in;
                end
                S_RUN: begin
                    case (r_step)
                        3'd2: r_acc <= w_t + AW'(r_st_q);
                        3'd3: begin
                            r_y   <= ysat(sat48(r_acc));
                            r_acc <= w_t + AW'(r_st_q);
                        end
                        3'd4: r_s2 <= w_t;
                        3'd5: r_acc <= r_acc - w_t;
                        3'd6: r_s2 <= r_s2 - w_t;
                        3'd7: begin
                            if (r_ch) r_r <= r_y;
                            else r_l <= r_y;
                        end
                        default: ;
                    endcase
                    if (r_step == 3'd7) begin
                        r_ch <= ~r_ch;
                        if (r_ch) r_band <= r_band + 1'b1;
                    end
                    r_step <= r_step + 3'd1;
                end
                S_OUT: begin
                    if (!r_ovalid || out_ch.ready) begin
                        r_lo <= r_l;
                        r_ro <= r_r;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid     = r_ovalid;
    assign out_ch.left_out  = r_lo;
    assign out_ch.right_out = r_ro;
endmodule

>>> design/sbeq_mac.sv
// Registered multiply, rounding to state scale.
module sbeq_mac import sbeq_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    output logic signed [STATE_BITS:0]    o_term
);
    localparam int SF_RAW     = STATE_BITS - SAMPLE_BITS - 4;
    localparam int STATE_FRAC = (SF_RAW < COEF_FRAC_BITS) ? SF_RAW : COEF_FRAC_BITS;
    localparam int SHIFT      = COEF_FRAC_BITS - STATE_FRAC;
    localparam int PW         = COEF_BITS + SAMPLE_BITS;
    localparam logic signed [PW:0] RND = (SHIFT > 0) ? ((PW+1)'(1) <<< (SHIFT - 1)) : '0;

    logic signed [PW-1:0] r_prod;
    logic signed [PW:0]   w_rnd;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_x;
    end

    // round half up, then floor shift
    always_comb begin
        w_rnd = (PW+1)'(r_prod);
        if (SHIFT > 0) begin
            w_rnd = (w_rnd + RND) >>> SHIFT;
        end
        o_term = (STATE_BITS+1)'(w_rnd);
    end
endmodule
